@@ rtl/core/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned SLOTS   = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned HELD_W  = 2;

  // expected sequence length codes
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  localparam logic [2:0] LEAD2_TAG = 3'h6;
  localparam logic [3:0] LEAD3_TAG = 4'hE;
  localparam logic [4:0] LEAD4_TAG = 5'h1E;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef logic [CP_W-1:0] cp_t;

  // results caused by one accepted byte
  typedef struct packed {
    cp_t [SLOTS-1:0]   cp;
    logic [CNT_W-1:0]  count;
    logic              eot;
  } burst_t;

  function automatic logic [2:0] seq_len(input logic [BYTE_W-1:0] b);
    logic [2:0] n;
    n = LEN_ONE;
    if (b[7:5] == LEAD2_TAG)      n = LEN_TWO;
    else if (b[7:4] == LEAD3_TAG) n = LEN_THREE;
    else if (b[7:3] == LEAD4_TAG) n = LEN_FOUR;
    return n;
  endfunction

endpackage

@@ rtl/core/utf8d_byte_if.sv @@
// ----------------------------------------------------------------------------
// utf8d_byte_if
// Byte channel: one text byte per transfer with an end of text flag.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_text;

  modport source (output valid, output byte_value, output end_of_text, input ready);
  modport sink   (input valid, input byte_value, input end_of_text, output ready);
endinterface

@@ rtl/core/utf8d_cp_if.sv @@
// ----------------------------------------------------------------------------
// utf8d_cp_if
// Code point channel: one decoded code point per transfer.
// ----------------------------------------------------------------------------
interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_of_run;
  logic        text_done;

  modport source (output valid, output code_point, output last_of_run,
                  output text_done, input ready);
  modport sink   (input valid, input code_point, input last_of_run,
                  input text_done, output ready);
endinterface

@@ rtl/core/utf8d_step.sv @@
// ----------------------------------------------------------------------------
// utf8d_step
// Sequence state and per-byte decode; produces the results of one byte.
// ----------------------------------------------------------------------------
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              end_of_text,
  output burst_t            burst
);

  logic [BYTE_W-1:0] lead, lead_next;
  logic [2:0]        exp_len, exp_len_next;
  logic [HELD_W-1:0] held_count, held_count_next;
  logic [BYTE_W-1:0] held [2];
  logic              hold_wr;

  logic [2:0] n;
  logic       cont;
  logic       fresh_emit;
  cp_t        b_cp, lead_cp, h0_cp, h1_cp, joined;

  always_comb begin
    n          = seq_len(byte_value);
    cont       = (byte_value & CONT_MASK) == CONT_TAG;
    fresh_emit = (n == LEN_ONE) || end_of_text;
    b_cp       = cp_t'(byte_value);
    lead_cp    = cp_t'(lead);
    h0_cp      = cp_t'(held[0]);
    h1_cp      = cp_t'(held[1]);

    case (exp_len)
      LEN_TWO:   joined = cp_t'({lead[4:0], byte_value[5:0]});
      LEN_THREE: joined = cp_t'({lead[3:0], held[0][5:0], byte_value[5:0]});
      default:   joined = {lead[2:0], held[0][5:0], held[1][5:0], byte_value[5:0]};
    endcase

    lead_next       = lead;
    exp_len_next    = exp_len;
    held_count_next = held_count;
    hold_wr         = 1'b0;
    burst.eot       = end_of_text;
    burst.count     = '0;
    burst.cp[0]     = lead_cp;
    burst.cp[1]     = (held_count != '0) ? h0_cp : b_cp;
    burst.cp[2]     = (held_count == 2'd2) ? h1_cp : b_cp;
    burst.cp[3]     = b_cp;

    if (exp_len == LEN_NONE) begin
      burst.cp[0] = b_cp;
      if (fresh_emit) begin
        burst.count = CNT_W'(1);
      end else begin
        lead_next       = byte_value;
        exp_len_next    = n;
        held_count_next = '0;
      end
    end else if (cont) begin
      if ({1'b0, held_count} + 3'd2 == exp_len) begin
        burst.cp[0]     = joined;
        burst.count     = CNT_W'(1);
        exp_len_next    = LEN_NONE;
        held_count_next = '0;
      end else if (end_of_text) begin
        burst.count = CNT_W'(held_count) + CNT_W'(2);
      end else begin
        hold_wr         = 1'b1;
        held_count_next = held_count + HELD_W'(1);
      end
    end else begin
      exp_len_next    = LEN_NONE;
      held_count_next = '0;
      if (fresh_emit) begin
        burst.count = CNT_W'(held_count) + CNT_W'(2);
      end else begin
        burst.count  = CNT_W'(held_count) + CNT_W'(1);
        lead_next    = byte_value;
        exp_len_next = n;
      end
    end

    if (end_of_text) begin
      exp_len_next    = LEN_NONE;
      held_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead       <= '0;
      exp_len    <= LEN_NONE;
      held_count <= '0;
    end else if (accept) begin
      lead       <= lead_next;
      exp_len    <= exp_len_next;
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_wr) begin
      held[held_count[0]] <= byte_value;
    end
  end

endmodule

@@ rtl/core/utf8d_burst.sv @@
// ----------------------------------------------------------------------------
// utf8d_burst
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module utf8d_burst
  import utf8d_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  burst_t burst_in,
  output logic   free,
  output logic   valid,
  input  logic   ready,
  output cp_t    code_point,
  output logic   last_of_run,
  output logic   text_done
);

  cp_t [SLOTS-1:0]  cp;
  logic [CNT_W-1:0] rem;
  logic             eot;
  logic             take;

  assign valid       = rem != '0;
  assign take        = valid && ready;
  assign free        = (rem == '0) || (rem == CNT_W'(1) && ready);
  assign code_point  = cp[0];
  assign last_of_run = rem == CNT_W'(1);
  assign text_done   = last_of_run && eot;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= burst_in.count;
    end else if (take) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp  <= burst_in.cp;
      eot <= burst_in.eot;
    end else if (take) begin
      cp <= {cp[SLOTS-1], cp[SLOTS-1:1]};
    end
  end

endmodule

@@ rtl/core/utf8_to_code_point_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top
// UTF-8 byte stream in, code points out; malformed runs pass through raw.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 rate
//  text     in   byte_value[7:0], end_of_text            1 byte / cycle when ready
//  points   out  code_point[20:0], last_of_run, text_done 1 result / cycle when ready
//
//  a byte is decoded in the cycle of its transfer into the result register
//  a byte with zero or one result keeps the input at one transfer per cycle while points.ready is high
//  a byte with more than one result holds text.ready low until its last result is taken
//  rst is synchronous and clears sequence state and empties the result register
//  a stall on points holds the result and stops input once the register is full
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_top
  import utf8d_pkg::*;
(
  input logic           clk,
  input logic           rst,
  utf8d_byte_if.sink    text,
  utf8d_cp_if.source    points
);

  logic   accept;
  logic   free;
  burst_t burst;

  assign text.ready = free;
  assign accept     = text.valid && free;

  utf8d_step u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_value  (text.byte_value),
    .end_of_text (text.end_of_text),
    .burst       (burst)
  );

  utf8d_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .burst_in    (burst),
    .free        (free),
    .valid       (points.valid),
    .ready       (points.ready),
    .code_point  (points.code_point),
    .last_of_run (points.last_of_run),
    .text_done   (points.text_done)
  );

endmodule

@@ rtl/core/utf8d_checker.sv @@
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder top level, bound to every instance.
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eot,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_cp,
  input logic        out_last,
  input logic        out_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cp) && $stable(out_last)
                                 && $stable(out_done))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_last)
    else $error("text_done without last_of_run");

  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eot |=> out_valid)
    else $error("final byte gave no result");

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken while a run is still draining");

endmodule

bind utf8_to_code_point_decoder_top utf8d_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .in_eot    (text.end_of_text),
  .out_valid (points.valid),
  .out_ready (points.ready),
  .out_cp    (points.code_point),
  .out_last  (points.last_of_run),
  .out_done  (points.text_done)
);
